/* rtl/ipcc_pkg.sv */
// Shared types, constants and helpers for the IPv4 text CIDR classifier.
package ipcc_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int ADDR_W      = 32;
    localparam int PROV_W      = 8;
    localparam int IDX_W       = 6;
    localparam int PLEN_W      = 6;
    localparam int CHAR_W      = 8;

    localparam logic [PLEN_W-1:0] MAX_PREFIX  = PLEN_W'(32);
    localparam logic [11:0]       OCTET_MAX   = 12'd255;
    localparam logic [CHAR_W-1:0] CHAR_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_CHAR  = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] mask;
        logic [PROV_W-1:0] provider;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        t_entry            entry;
        logic              valid;
    } t_tbl_wr;

    // Prefix length to network mask; zero length gives an empty mask.
    function automatic logic [ADDR_W-1:0] make_mask(input logic [PLEN_W-1:0] plen);
        logic [PLEN_W-1:0] sh;
        sh = MAX_PREFIX - plen;
        if (plen == '0) begin
            return '0;
        end
        return {ADDR_W{1'b1}} << sh;
    endfunction

endpackage

/* rtl/ipcc_table.sv */
// Range table: entry memory with one write and one registered read port, plus valid bits.
module ipcc_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ipcc_pkg::t_tbl_wr           i_wr,
    input  logic                        i_rd_en,
    input  logic [ipcc_pkg::SLOT_W-1:0] i_rd_slot,
    output ipcc_pkg::t_entry            o_rd_entry,
    output logic                        o_rd_valid
);

    ipcc_pkg::t_entry                   r_mem [ipcc_pkg::TABLE_SLOTS];
    logic [ipcc_pkg::TABLE_SLOTS-1:0]   r_valid;
    ipcc_pkg::t_entry                   r_rd_entry;
    logic                               r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.slot] <= i_wr.entry;
        end
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_slot];
        end
    end

    // Valid bits clear on reset so unwritten slots never match.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.slot] <= i_wr.valid;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_slot];
            end
        end
    end

    assign o_rd_entry = r_rd_entry;
    assign o_rd_valid = r_rd_valid;

endmodule

/* rtl/ipv4_text_cidr_classifier.sv */
// Top level: dotted-quad text parser, first-hit CIDR table scan and result register.
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+-------------------------------------------
//  input     | start in, busy out            | i_func, i_entry_index, i_range_base,
//            | beat taken when start & !busy | i_prefix_length, i_provider_code,
//            |                               | i_entry_enable, i_text_char, i_last_char
//  result    | o_result_valid, one cycle     | o_address_ok, o_address_value, o_matched,
//            |                               | o_match_provider, o_match_slot
//
// A table write or a non-final character is taken without a wait; busy stays low.
// A final character of malformed text gives its result in the next cycle.
// A final character of a good address starts a scan of the entry memory, one
// entry per cycle through its single registered read port: busy stays high
// until an entry hits or the last entry has been checked.
// Reset (i_rst_n low, synchronous) clears all valid bits and the parser.
// The receiver cannot stall: each result beat shows for exactly one cycle.
module ipv4_text_cidr_classifier (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_func,
    input  logic [ipcc_pkg::IDX_W-1:0]  i_entry_index,
    input  logic [ipcc_pkg::ADDR_W-1:0] i_range_base,
    input  logic [ipcc_pkg::PLEN_W-1:0] i_prefix_length,
    input  logic [ipcc_pkg::PROV_W-1:0] i_provider_code,
    input  logic                        i_entry_enable,
    input  logic [ipcc_pkg::CHAR_W-1:0] i_text_char,
    input  logic                        i_last_char,
    output logic                        o_result_valid,
    output logic                        o_address_ok,
    output logic [ipcc_pkg::ADDR_W-1:0] o_address_value,
    output logic                        o_matched,
    output logic [ipcc_pkg::PROV_W-1:0] o_match_provider,
    output logic [ipcc_pkg::IDX_W-1:0]  o_match_slot
);

    localparam logic [ipcc_pkg::SLOT_W-1:0] LAST_SLOT =
        ipcc_pkg::SLOT_W'(ipcc_pkg::TABLE_SLOTS - 1);

    // ---------------------------------------------------------------
    // Beat acceptance
    // ---------------------------------------------------------------
    logic accept;
    logic wr_beat;
    logic char_beat;

    assign accept    = start && !busy;
    assign wr_beat   = accept && (i_func == ipcc_pkg::FUNC_WRITE);
    assign char_beat = accept && (i_func == ipcc_pkg::FUNC_CHAR);

    // ---------------------------------------------------------------
    // Table write: build mask, mask base, drop bad prefix or slot
    // ---------------------------------------------------------------
    ipcc_pkg::t_tbl_wr         tbl_wr;
    logic [ipcc_pkg::ADDR_W-1:0] wr_mask;

    assign wr_mask = ipcc_pkg::make_mask(i_prefix_length);

    always_comb begin
        tbl_wr.en = wr_beat && (i_prefix_length <= ipcc_pkg::MAX_PREFIX)
                    && (32'(i_entry_index) < 32'(ipcc_pkg::TABLE_SLOTS));
        tbl_wr.slot           = ipcc_pkg::SLOT_W'(i_entry_index);
        tbl_wr.entry.base     = i_range_base & wr_mask;
        tbl_wr.entry.mask     = wr_mask;
        tbl_wr.entry.provider = i_provider_code;
        tbl_wr.valid          = i_entry_enable;
    end

    // ---------------------------------------------------------------
    // Text parser: one character per beat
    // ---------------------------------------------------------------
    logic [23:0] r_acc;      // first three octets, shifted in
    logic [7:0]  r_octet;
    logic [1:0]  r_digits;
    logic [1:0]  r_octets;
    logic        r_bad;

    logic [23:0] n_acc;
    logic [7:0]  n_octet;
    logic [1:0]  n_digits;
    logic [1:0]  n_octets;
    logic        n_bad;
    logic [11:0] digit_next;
    logic        text_ok;

    assign digit_next = 12'(r_octet) * 12'd10
                      + 12'(i_text_char - ipcc_pkg::CHAR_ZERO);

    always_comb begin
        n_acc    = r_acc;
        n_octet  = r_octet;
        n_digits = r_digits;
        n_octets = r_octets;
        n_bad    = r_bad;
        if (!r_bad) begin
            if (i_text_char inside {[ipcc_pkg::CHAR_ZERO:ipcc_pkg::CHAR_NINE]}) begin
                // A fourth digit or an octet above 255 spoils the text.
                if ((r_digits == 2'd3) || (digit_next > ipcc_pkg::OCTET_MAX)) begin
                    n_bad = 1'b1;
                end else begin
                    n_octet  = digit_next[7:0];
                    n_digits = r_digits + 2'd1;
                end
            end else if (i_text_char == ipcc_pkg::CHAR_DOT) begin
                // Empty octet, or a dot after the fourth octet.
                if ((r_digits == 2'd0) || (r_octets == 2'd3)) begin
                    n_bad = 1'b1;
                end else begin
                    n_acc    = {r_acc[15:0], r_octet};
                    n_octets = r_octets + 2'd1;
                    n_octet  = '0;
                    n_digits = '0;
                end
            end else begin
                n_bad = 1'b1;
            end
        end
    end

    assign text_ok = !n_bad && (n_octets == 2'd3) && (n_digits != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_octet  <= '0;
            r_digits <= '0;
            r_octets <= '0;
            r_bad    <= 1'b0;
        end else if (char_beat) begin
            if (i_last_char) begin
                // Return the parser to its idle state after every address.
                r_acc    <= '0;
                r_octet  <= '0;
                r_digits <= '0;
                r_octets <= '0;
                r_bad    <= 1'b0;
            end else begin
                r_acc    <= n_acc;
                r_octet  <= n_octet;
                r_digits <= n_digits;
                r_octets <= n_octets;
                r_bad    <= n_bad;
            end
        end
    end

    // ---------------------------------------------------------------
    // Scan sequencer: issue one read per cycle, compare its registered data in the next cycle, no later
    // ---------------------------------------------------------------
    ipcc_pkg::t_state            r_state, n_state;
    logic [ipcc_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [ipcc_pkg::SLOT_W-1:0] r_idx, n_idx;
    logic                        r_issued, n_issued;    // last slot already read
    logic                        r_chk, n_chk;          // read data due this cycle
    logic [ipcc_pkg::SLOT_W-1:0] r_chk_idx, n_chk_idx;

    logic                        r_stb, n_stb;
    logic                        r_ok, n_ok;
    logic [ipcc_pkg::ADDR_W-1:0] r_val, n_val;
    logic                        r_hit, n_hit;
    logic [ipcc_pkg::PROV_W-1:0] r_prov, n_prov;
    logic [ipcc_pkg::IDX_W-1:0]  r_slot, n_slot;

    logic                        rd_en;
    ipcc_pkg::t_entry            rd_entry;
    logic                        rd_valid;
    logic                        entry_hit;

    assign entry_hit = rd_valid && ((r_addr & rd_entry.mask) == rd_entry.base);

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_idx     = r_idx;
        n_issued  = r_issued;
        n_chk     = 1'b0;
        n_chk_idx = r_idx;
        n_stb     = 1'b0;
        n_ok      = r_ok;
        n_val     = r_val;
        n_hit     = r_hit;
        n_prov    = r_prov;
        n_slot    = r_slot;
        rd_en     = 1'b0;
        case (r_state)
            ipcc_pkg::S_IDLE: begin
                if (char_beat && i_last_char) begin
                    if (text_ok) begin
                        n_addr   = {n_acc, n_octet};
                        n_idx    = '0;
                        n_issued = 1'b0;
                        n_state  = ipcc_pkg::S_SCAN;
                    end else begin
                        // Malformed text: report all zero at once.
                        n_stb  = 1'b1;
                        n_ok   = 1'b0;
                        n_val  = '0;
                        n_hit  = 1'b0;
                        n_prov = '0;
                        n_slot = '0;
                    end
                end
            end
            ipcc_pkg::S_SCAN: begin
                rd_en = !r_issued;
                if (!r_issued) begin
                    n_chk     = 1'b1;
                    n_chk_idx = r_idx;
                    n_idx     = r_idx + 1'b1;
                    n_issued  = (r_idx == LAST_SLOT);
                end
                if (r_chk) begin
                    if (entry_hit) begin
                        // First hit in index order wins; drop the rest.
                        n_stb   = 1'b1;
                        n_ok    = 1'b1;
                        n_val   = r_addr;
                        n_hit   = 1'b1;
                        n_prov  = rd_entry.provider;
                        n_slot  = ipcc_pkg::IDX_W'(r_chk_idx);
                        n_chk   = 1'b0;
                        n_state = ipcc_pkg::S_IDLE;
                    end else if (r_chk_idx == LAST_SLOT) begin
                        n_stb   = 1'b1;
                        n_ok    = 1'b1;
                        n_val   = r_addr;
                        n_hit   = 1'b0;
                        n_prov  = '0;
                        n_slot  = '0;
                        n_chk   = 1'b0;
                        n_state = ipcc_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = ipcc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ipcc_pkg::S_IDLE;
            r_issued <= 1'b0;
            r_chk    <= 1'b0;
            r_stb    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            r_chk    <= n_chk;
            r_stb    <= n_stb;
        end
    end

    // Payload and scan position: no reset needed.
    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_idx     <= n_idx;
        r_chk_idx <= n_chk_idx;
        r_ok      <= n_ok;
        r_val     <= n_val;
        r_hit     <= n_hit;
        r_prov    <= n_prov;
        r_slot    <= n_slot;
    end

    ipcc_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (tbl_wr),
        .i_rd_en    (rd_en),
        .i_rd_slot  (r_idx),
        .o_rd_entry (rd_entry),
        .o_rd_valid (rd_valid)
    );

    // ---------------------------------------------------------------
    // Outputs
    // ---------------------------------------------------------------
    assign busy             = (r_state != ipcc_pkg::S_IDLE);
    assign o_result_valid   = r_stb;
    assign o_address_ok     = r_ok;
    assign o_address_value  = r_val;
    assign o_matched        = r_hit;
    assign o_match_provider = r_prov;
    assign o_match_slot     = r_slot;

endmodule

/* tb/tb_ipv4_text_cidr_classifier.sv */
// Self-checking testbench for the IPv4 text CIDR classifier: directed and random beats.
module tb_ipv4_text_cidr_classifier;

    localparam int CLK_HALF     = 5;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_BEATS = 640;
    // A lookup scans at most every slot once, plus the result register.
    localparam int DRAIN_CYCLES = ipcc_pkg::TABLE_SLOTS + 8;

    typedef logic [ipcc_pkg::CHAR_W-1:0] t_char_q[$];

    // One input beat, every field of the command bus.
    typedef struct {
        logic                        func;
        logic [ipcc_pkg::IDX_W-1:0]  slot;
        logic [ipcc_pkg::ADDR_W-1:0] base;
        logic [ipcc_pkg::PLEN_W-1:0] plen;
        logic [ipcc_pkg::PROV_W-1:0] prov;
        logic                        en;
        logic [ipcc_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } t_beat;

    // One lookup verdict, as the result ports show it.
    typedef struct {
        logic                        ok;
        logic [ipcc_pkg::ADDR_W-1:0] addr;
        logic                        hit;
        logic [ipcc_pkg::PROV_W-1:0] prov;
        logic [ipcc_pkg::IDX_W-1:0]  slot;
    } t_verdict;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic                          i_func;
    logic [ipcc_pkg::IDX_W-1:0]    i_entry_index;
    logic [ipcc_pkg::ADDR_W-1:0]   i_range_base;
    logic [ipcc_pkg::PLEN_W-1:0]   i_prefix_length;
    logic [ipcc_pkg::PROV_W-1:0]   i_provider_code;
    logic                          i_entry_enable;
    logic [ipcc_pkg::CHAR_W-1:0]   i_text_char;
    logic                          i_last_char;
    logic                          o_result_valid;
    logic                          o_address_ok;
    logic [ipcc_pkg::ADDR_W-1:0]   o_address_value;
    logic                          o_matched;
    logic [ipcc_pkg::PROV_W-1:0]   o_match_provider;
    logic [ipcc_pkg::IDX_W-1:0]    o_match_slot;

    // Predicted range table and text parser state.
    logic [ipcc_pkg::ADDR_W-1:0] rng_base  [ipcc_pkg::TABLE_SLOTS];
    logic [ipcc_pkg::ADDR_W-1:0] rng_mask  [ipcc_pkg::TABLE_SLOTS];
    logic [ipcc_pkg::PROV_W-1:0] rng_prov  [ipcc_pkg::TABLE_SLOTS];
    bit                          rng_valid [ipcc_pkg::TABLE_SLOTS];
    logic [ipcc_pkg::ADDR_W-1:0] txt_addr;
    int                          txt_octet;
    int                          txt_digits;
    int                          txt_octets;
    bit                          txt_bad;

    t_verdict verdict_q[$];
    int       errors      = 0;
    int       beats_sent  = 0;
    int       cycle_count = 0;
    int       gap_pct     = 17;

    ipv4_text_cidr_classifier i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_entry_index    (i_entry_index),
        .i_range_base     (i_range_base),
        .i_prefix_length  (i_prefix_length),
        .i_provider_code  (i_provider_code),
        .i_entry_enable   (i_entry_enable),
        .i_text_char      (i_text_char),
        .i_last_char      (i_last_char),
        .o_result_valid   (o_result_valid),
        .o_address_ok     (o_address_ok),
        .o_address_value  (o_address_value),
        .o_matched        (o_matched),
        .o_match_provider (o_match_provider),
        .o_match_slot     (o_match_slot)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs with busy high or a result never shows.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Advance the predictor by one accepted beat; return 1 when it yields a verdict.
    function automatic bit classify_beat(input t_beat b, output t_verdict v);
        int                          next_val;
        logic [ipcc_pkg::ADDR_W-1:0] a;
        v = '{default: 0};
        if (b.func == ipcc_pkg::FUNC_WRITE) begin
            // Prefix lengths above 32 drop the write entirely.
            if (b.plen <= ipcc_pkg::MAX_PREFIX && b.slot < ipcc_pkg::TABLE_SLOTS) begin
                rng_mask[b.slot]  = ~({ipcc_pkg::ADDR_W{1'b1}} >> b.plen);
                rng_base[b.slot]  = b.base & ~({ipcc_pkg::ADDR_W{1'b1}} >> b.plen);
                rng_prov[b.slot]  = b.prov;
                rng_valid[b.slot] = b.en;
            end
            return 1'b0;
        end
        // Once the text is bad, swallow everything up to the last character.
        if (!txt_bad) begin
            if (b.ch >= ipcc_pkg::CHAR_ZERO && b.ch <= ipcc_pkg::CHAR_NINE) begin
                next_val = txt_octet * 10 + int'(b.ch - ipcc_pkg::CHAR_ZERO);
                if (txt_digits >= 3 || next_val > int'(ipcc_pkg::OCTET_MAX)) begin
                    txt_bad = 1'b1;
                end else begin
                    txt_octet = next_val;
                    txt_digits++;
                end
            end else if (b.ch == ipcc_pkg::CHAR_DOT) begin
                if (txt_digits == 0 || txt_octets >= 3) begin
                    txt_bad = 1'b1;
                end else begin
                    txt_addr   = {txt_addr[ipcc_pkg::ADDR_W-9:0], 8'(txt_octet)};
                    txt_octets++;
                    txt_octet  = 0;
                    txt_digits = 0;
                end
            end else begin
                txt_bad = 1'b1;
            end
        end
        if (!b.last) begin
            return 1'b0;
        end
        if (!txt_bad && txt_octets == 3 && txt_digits > 0) begin
            a      = {txt_addr[ipcc_pkg::ADDR_W-9:0], 8'(txt_octet)};
            v.ok   = 1'b1;
            v.addr = a;
            // Lowest slot index wins among overlapping ranges.
            for (int i = 0; i < ipcc_pkg::TABLE_SLOTS; i++) begin
                if (rng_valid[i] && (a & rng_mask[i]) == rng_base[i]) begin
                    v.hit  = 1'b1;
                    v.prov = rng_prov[i];
                    v.slot = ipcc_pkg::IDX_W'(i);
                    break;
                end
            end
        end
        txt_addr   = '0;
        txt_octet  = 0;
        txt_digits = 0;
        txt_octets = 0;
        txt_bad    = 1'b0;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [ipcc_pkg::ADDR_W-1:0] want,
                               input logic [ipcc_pkg::ADDR_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare every result beat against the oldest pending verdict.
    always @(posedge i_clk) begin : result_check
        t_verdict want;
        if (i_rst_n && o_result_valid) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual addr %0h",
                         $time, o_address_value);
                errors++;
            end else begin
                want = verdict_q.pop_front();
                check_field("address_ok", ipcc_pkg::ADDR_W'(want.ok),
                            ipcc_pkg::ADDR_W'(o_address_ok));
                check_field("address_value", want.addr, o_address_value);
                check_field("matched", ipcc_pkg::ADDR_W'(want.hit),
                            ipcc_pkg::ADDR_W'(o_matched));
                check_field("match_provider", ipcc_pkg::ADDR_W'(want.prov),
                            ipcc_pkg::ADDR_W'(o_match_provider));
                check_field("match_slot", ipcc_pkg::ADDR_W'(want.slot),
                            ipcc_pkg::ADDR_W'(o_match_slot));
            end
        end
    end

    // Drive one beat at the falling edge and hold it until start & !busy is seen.
    task automatic send_beat(input t_beat b);
        t_verdict v;
        while ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start           = 1'b1;
        i_func          = b.func;
        i_entry_index   = b.slot;
        i_range_base    = b.base;
        i_prefix_length = b.plen;
        i_provider_code = b.prov;
        i_entry_enable  = b.en;
        i_text_char     = b.ch;
        i_last_char     = b.last;
        do @(posedge i_clk); while (busy);
        beats_sent++;
        if (classify_beat(b, v)) begin
            verdict_q.insert(verdict_q.size(), v);
        end
    endtask

    // Randomize every field; the ones the beat kind ignores stay as noise.
    function automatic t_beat filler_beat(input logic func);
        t_beat b;
        b.func = func;
        b.slot = ipcc_pkg::IDX_W'($urandom);
        b.base = $urandom;
        b.plen = ipcc_pkg::PLEN_W'($urandom);
        b.prov = ipcc_pkg::PROV_W'($urandom);
        b.en   = 1'($urandom);
        b.ch   = ipcc_pkg::CHAR_W'($urandom);
        b.last = 1'($urandom);
        return b;
    endfunction

    task automatic send_write(input int slot, input logic [ipcc_pkg::ADDR_W-1:0] base,
                              input int plen, input logic [ipcc_pkg::PROV_W-1:0] prov,
                              input logic en);
        t_beat b;
        b      = filler_beat(ipcc_pkg::FUNC_WRITE);
        b.slot = ipcc_pkg::IDX_W'(slot);
        b.base = base;
        b.plen = ipcc_pkg::PLEN_W'(plen);
        b.prov = prov;
        b.en   = en;
        send_beat(b);
    endtask

    task automatic send_text(input t_char_q t);
        t_beat b;
        foreach (t[i]) begin
            b      = filler_beat(ipcc_pkg::FUNC_CHAR);
            b.ch   = t[i];
            b.last = (i == t.size() - 1);
            send_beat(b);
        end
    endtask

    function automatic t_char_q text_of(input string s);
        t_char_q q;
        for (int i = 0; i < s.len(); i++) begin
            q.insert(q.size(), s[i]);
        end
        return q;
    endfunction

    // Format an address as a dotted quad, sometimes with leading zeros.
    function automatic t_char_q quad_text(input logic [ipcc_pkg::ADDR_W-1:0] a);
        t_char_q q;
        string   s;
        for (int k = 3; k >= 0; k--) begin
            s = $sformatf("%0d", a[8*k +: 8]);
            if ($urandom_range(5) == 0) begin
                while (s.len() < 3) begin
                    s = {"0", s};
                end
            end
            for (int i = 0; i < s.len(); i++) begin
                q.insert(q.size(), s[i]);
            end
            if (k != 0) begin
                q.insert(q.size(), ipcc_pkg::CHAR_DOT);
            end
        end
        return q;
    endfunction

    // Half the time aim inside a live range so lookups hit; else lean on 0 and 255.
    function automatic logic [ipcc_pkg::ADDR_W-1:0] pick_address();
        logic [ipcc_pkg::ADDR_W-1:0] a;
        int                          j;
        j = $urandom_range(ipcc_pkg::TABLE_SLOTS - 1);
        if ($urandom_range(1) == 1 && rng_valid[j]) begin
            a = rng_base[j] | ($urandom & ~rng_mask[j]);
        end else begin
            for (int k = 0; k < 4; k++) begin
                case ($urandom_range(3))
                    0:       a[8*k +: 8] = 8'h00;
                    1:       a[8*k +: 8] = 8'hFF;
                    default: a[8*k +: 8] = 8'($urandom);
                endcase
            end
        end
        return a;
    endfunction

    // Break a well-formed text in one of several ways.
    function automatic t_char_q mangle(input t_char_q t);
        int    p;
        string s;
        p = $urandom_range(t.size() - 1);
        case ($urandom_range(5))
            0: t[p] = ipcc_pkg::CHAR_W'($urandom);
            1: t.insert(p, ipcc_pkg::CHAR_ZERO + ipcc_pkg::CHAR_W'($urandom_range(9)));
            2: if (t.size() > 1) begin
                t.delete(p);
            end
            3: begin
                // trailing fifth octet
                t.insert(t.size(), ipcc_pkg::CHAR_DOT);
                t.insert(t.size(),
                         ipcc_pkg::CHAR_ZERO + ipcc_pkg::CHAR_W'($urandom_range(9)));
            end
            4: begin
                // pure noise, weighted toward digits and dots
                t.delete();
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(1) == 1) begin
                        t.insert(t.size(), ipcc_pkg::CHAR_W'($urandom));
                    end else if ($urandom_range(3) == 0) begin
                        t.insert(t.size(), ipcc_pkg::CHAR_DOT);
                    end else begin
                        t.insert(t.size(),
                                 ipcc_pkg::CHAR_ZERO + ipcc_pkg::CHAR_W'($urandom_range(9)));
                    end
                end
            end
            default: begin
                // first octet out of range
                while (t.size() > 0 && t[0] != ipcc_pkg::CHAR_DOT) begin
                    void'(t.pop_front());
                end
                s = $sformatf("%0d", $urandom_range(256, 999));
                for (int i = s.len() - 1; i >= 0; i--) begin
                    t.push_front(s[i]);
                end
            end
        endcase
        return t;
    endfunction

    // Write every slot once, disabled, so no lookup ever scans an unwritten entry.
    task automatic clear_table();
        for (int i = 0; i < ipcc_pkg::TABLE_SLOTS; i++) begin
            send_write(i, $urandom, $urandom_range(32), ipcc_pkg::PROV_W'($urandom), 1'b0);
        end
    endtask

    // Overlapping ranges, base masking, ignored writes and disabling a slot.
    task automatic test_first_hit();
        send_write(5, 32'h0A01_0203, 8, 8'hA5, 1'b1);
        send_write(2, 32'h0A01_0203, 32, 8'h01, 1'b1);
        send_write(ipcc_pkg::TABLE_SLOTS - 1, 32'hFFFF_FFFF, 0, 8'hFF, 1'b1);
        send_write(2, 32'h0000_0000, 33, 8'h77, 1'b0);
        send_write(5, 32'h0000_0000, 63, 8'h00, 1'b0);
        send_text(text_of("10.1.2.3"));
        send_write(2, 32'h0A01_0203, 32, 8'h01, 1'b0);
        send_text(text_of("10.1.2.3"));
    endtask

    // Each way the text can go bad, plus too few octets.
    task automatic test_text_forms();
        t_char_q t;
        t = {8'hFF};
        send_text(text_of("1234"));
        send_text(text_of("256"));
        send_text(text_of("."));
        send_text(text_of("1.2.3.4."));
        send_text(t);
        send_text(text_of("9.8.7"));
    endtask

    // Mostly well-formed lookups with random content, some table churn and broken text.
    task automatic test_random_mix();
        int      first;
        int      n;
        int      roll;
        int      plen;
        t_char_q t;
        first = beats_sent;
        while (beats_sent - first < RANDOM_BEATS) begin
            n = beats_sent - first;
            // Hold the sender back-to-back for a long stretch.
            gap_pct = (n >= 250 && n < 450) ? 0 : 17;
            roll = $urandom_range(99);
            if (roll < 15) begin
                case ($urandom_range(19))
                    0:       plen = 0;
                    1, 2:    plen = $urandom_range(33, 63);
                    default: plen = $urandom_range(1, 32);
                endcase
                send_write($urandom_range(ipcc_pkg::TABLE_SLOTS - 1),
                           ($urandom_range(1) == 1) ? pick_address()
                                                    : ipcc_pkg::ADDR_W'($urandom),
                           plen, ipcc_pkg::PROV_W'($urandom), $urandom_range(4) != 0);
            end else begin
                t = quad_text(pick_address());
                if (roll >= 75) begin
                    t = mangle(t);
                end
                send_text(t);
            end
        end
        gap_pct = 17;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_func          = ipcc_pkg::FUNC_WRITE;
        i_entry_index   = '0;
        i_range_base    = '0;
        i_prefix_length = '0;
        i_provider_code = '0;
        i_entry_enable  = 1'b0;
        i_text_char     = '0;
        i_last_char     = 1'b0;
        for (int i = 0; i < ipcc_pkg::TABLE_SLOTS; i++) begin
            rng_base[i]  = '0;
            rng_mask[i]  = '0;
            rng_prov[i]  = '0;
            rng_valid[i] = 1'b0;
        end
        txt_addr   = '0;
        txt_octet  = 0;
        txt_digits = 0;
        txt_octets = 0;
        txt_bad    = 1'b0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        clear_table();
        test_first_hit();
        test_text_forms();
        test_random_mix();

        // Drop start before the next edge so the last beat is not taken twice.
        @(negedge i_clk);
        start = 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
